FILE: hw/rtl/spt_pkg.sv
// Package for the stylus printer timing model: period, position and status constants.
// Used by stylus_printer_timing_model_core and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package spt_pkg;

	typedef logic [8:0] period_t;
	typedef logic signed [9:0] pixel_t;

	localparam period_t PERIOD_FAST = 9'd220;
	localparam period_t PERIOD_SLOW = 9'd440;
	localparam period_t PERIOD_NONE = 9'd0;
	localparam period_t LINE_SPAN = 9'd384;

	localparam int ELAPSED_W = 25;
	localparam logic [ELAPSED_W-1:0] MAX_ELAPSED = 25'd23475200;

	localparam logic [8:0] LEAD_IN = 9'd64;
	localparam logic [8:0] BUSY_LO = 9'd55;
	localparam logic [8:0] BUSY_HI = 9'd63;

	localparam logic [7:0] STATUS_IDLE = 8'h3e;
	localparam logic [7:0] STATUS_BUSY = 8'hbe;

	localparam int CTRL_STYLUS = 7;
	localparam int CTRL_STOP = 2;
	localparam int CTRL_SLOW = 1;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

endpackage

`default_nettype wire

FILE: hw/rtl/stylus_printer_timing_model_core.sv
// Top level of the stylus printer timing model: sequencer, bit-serial divider and state.
// Depends on spt_pkg for periods, position limits and status codes.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   kind, control_byte, timestamp
// rsp      out        rsp_valid/rsp_stall   status_byte
//
// A write with the motor stopped is handled in the idle state; a read with the motor
// stopped goes to the result state, which shows the result before the next beat is taken.
// With the motor running a beat passes a setup state, a 25-step bit-serial divide of the
// elapsed time by the pixel period, the line step, an 18-step divide by the 384-pixel
// line length, one bit a cycle, a finish state, and then the result state for a read or
// the advance state for a write, which commits the new position and speed.
// req_stall is high while a beat is in work; a waiting result holds in the output register.
// Reset sets the motor off, the period fast and the line origin to zero.

module stylus_printer_timing_model_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire logic                 kind,
	input  wire logic [7:0]           control_byte,
	input  wire logic [63:0]          timestamp,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output logic [7:0]                status_byte
);
	import spt_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUB  = 3'd1;
	localparam logic [2:0] ST_DIV1 = 3'd2;
	localparam logic [2:0] ST_STEP = 3'd3;
	localparam logic [2:0] ST_DIV2 = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_ADV  = 3'd6;
	localparam logic [2:0] ST_RES  = 3'd7;

	localparam logic [4:0] DIV1_LAST = 5'(ELAPSED_W - 1);
	localparam logic [4:0] DIV2_LAST = 5'd17;

	logic [2:0]  state_q;
	logic        motor_q;
	logic        stylus_q;
	period_t     per_q;
	period_t     pend_q;
	logic [63:0] origin_q;
	pixel_t      pix_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;

	logic        kind_q;
	logic [7:0]  ctrl_q;
	logic [63:0] ts_q;
	logic [ELAPSED_W-1:0] dq_q;
	logic [8:0]  rem_q;
	period_t     dvs_q;
	logic [4:0]  cnt_q;
	logic        crossed_q;
	logic        zero_q;
	period_t     per1_q;
	logic [18:0] prod_q;
	logic [7:0]  st_q;

	logic [10:0] div_sub;
	logic        div_ge;
	logic [8:0]  rem_next;
	logic [ELAPSED_W-1:0] dq_next;

	logic [63:0] elapsed_full;
	logic [ELAPSED_W-1:0] elapsed;

	logic [16:0] step_q;
	logic        step_cross;
	logic [16:0] step_t;
	logic [17:0] step_u;
	logic [17:0] step_d;
	logic        step_zero;
	period_t     step_per1;

	logic [8:0]  fin_u;
	logic signed [10:0] fin_x;
	logic signed [10:0] fin_pix;
	logic        fin_busy;
	logic [7:0]  fin_status;

	logic        adv_lead;
	pixel_t      adv_x;
	logic [19:0] adv_sum;
	logic [28:0] adv_cycles;
	period_t     adv_req;
	period_t     adv_pend;

	logic        out_space;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign status_byte = out_byte_q;
	assign out_space = !out_valid_q || !rsp_stall;

	always_comb begin
		div_sub = {1'b0, rem_q, dq_q[ELAPSED_W-1]} - {2'b00, dvs_q};
		div_ge = !div_sub[10];
		rem_next = div_ge ? div_sub[8:0] : {rem_q[7:0], dq_q[ELAPSED_W-1]};
		dq_next = {dq_q[ELAPSED_W-2:0], div_ge};
	end

	always_comb begin
		elapsed_full = ts_q - origin_q;
		if (elapsed_full > 64'(MAX_ELAPSED)) begin
			elapsed = MAX_ELAPSED;
		end else begin
			elapsed = elapsed_full[ELAPSED_W-1:0];
		end
	end

	always_comb begin
		step_q = dq_q[16:0];
		step_cross = (kind_q == KIND_WRITE) ? (step_q >= 17'(LINE_SPAN))
			: (step_q > 17'(LINE_SPAN));
		step_t = step_q - 17'(LINE_SPAN);
		step_u = {1'b0, step_q};
		step_per1 = per_q;
		if (step_cross) begin
			step_u = {1'b0, step_t};
			if (pend_q != PERIOD_NONE) begin
				step_per1 = pend_q;
				if (per_q == PERIOD_FAST && pend_q == PERIOD_SLOW) begin
					step_u = {2'b00, step_t[16:1]};
				end else if (per_q == PERIOD_SLOW && pend_q == PERIOD_FAST) begin
					step_u = {step_t, 1'b0};
				end
			end
		end
		step_zero = (kind_q == KIND_READ) && (step_u == 18'd0);
		if (kind_q == KIND_WRITE) begin
			step_d = step_u;
		end else if (step_zero) begin
			step_d = 18'd0;
		end else begin
			step_d = step_u - 18'd1;
		end
	end

	always_comb begin
		fin_u = zero_q ? 9'd0 : rem_q + 9'd1;
		fin_x = $signed({2'b00, fin_u}) - $signed({2'b00, LEAD_IN});
		fin_pix = crossed_q ? -11'sd1 : {pix_q[9], pix_q};
		fin_busy = stylus_q || (fin_u >= BUSY_LO && fin_u <= BUSY_HI);
		fin_status = fin_busy ? STATUS_BUSY : STATUS_IDLE;
		if (fin_x > fin_pix) begin
			fin_status[0] = 1'b1;
		end
	end

	always_comb begin
		adv_lead = (rem_q < LEAD_IN);
		adv_x = adv_lead ? -10'sd1 : $signed(10'(rem_q - LEAD_IN));
		adv_sum = {1'b0, prod_q} + (crossed_q ? {11'd0, per_q} : 20'd0);
		adv_cycles = {1'b0, adv_sum, 8'd0} + {2'b00, adv_sum, 7'd0};
		adv_req = ctrl_q[CTRL_SLOW] ? PERIOD_SLOW : PERIOD_FAST;
		adv_pend = crossed_q ? PERIOD_NONE : pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			motor_q <= 1'b0;
			stylus_q <= 1'b0;
			per_q <= PERIOD_FAST;
			pend_q <= PERIOD_NONE;
			origin_q <= 64'd0;
			pix_q <= -10'sd1;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RES && out_space) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						if (!motor_q) begin
							if (kind == KIND_READ) begin
								state_q <= ST_RES;
							end else if (!control_byte[CTRL_STOP]) begin
								motor_q <= 1'b1;
								per_q <= control_byte[CTRL_SLOW] ? PERIOD_SLOW : PERIOD_FAST;
								pend_q <= PERIOD_NONE;
								origin_q <= timestamp;
								stylus_q <= control_byte[CTRL_STYLUS];
								pix_q <= -10'sd1;
							end
						end else begin
							state_q <= ST_SUB;
						end
					end
				end
				ST_SUB: begin
					state_q <= ST_DIV1;
				end
				ST_DIV1: begin
					if (cnt_q == 5'd0) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					if (cnt_q == 5'd0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= (kind_q == KIND_READ) ? ST_RES : ST_ADV;
				end
				ST_ADV: begin
					state_q <= ST_IDLE;
					origin_q <= origin_q + 64'(adv_cycles);
					if (ctrl_q[CTRL_STOP]) begin
						motor_q <= 1'b0;
						stylus_q <= 1'b0;
						per_q <= per1_q;
						pend_q <= adv_pend;
					end else begin
						pix_q <= adv_x;
						stylus_q <= ctrl_q[CTRL_STYLUS];
						if (adv_lead) begin
							per_q <= adv_req;
							pend_q <= PERIOD_NONE;
						end else begin
							per_q <= per1_q;
							pend_q <= (adv_req == per1_q) ? PERIOD_NONE : adv_req;
						end
					end
				end
				ST_RES: begin
					if (out_space) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				kind_q <= kind;
				ctrl_q <= control_byte;
				ts_q <= timestamp;
				st_q <= STATUS_IDLE;
			end
			ST_SUB: begin
				dq_q <= elapsed;
				rem_q <= 9'd0;
				dvs_q <= per_q;
				cnt_q <= DIV1_LAST;
			end
			ST_DIV1, ST_DIV2: begin
				dq_q <= dq_next;
				rem_q <= rem_next;
				cnt_q <= cnt_q - 5'd1;
			end
			ST_STEP: begin
				dq_q <= {step_d, 7'd0};
				rem_q <= 9'd0;
				dvs_q <= LINE_SPAN;
				cnt_q <= DIV2_LAST;
				crossed_q <= step_cross;
				zero_q <= step_zero;
				per1_q <= step_per1;
			end
			ST_FIN: begin
				st_q <= fin_status;
				prod_q <= dq_q[9:0] * per1_q;
			end
			ST_RES: begin
				if (out_space) begin
					out_byte_q <= st_q;
				end
			end
			default: begin
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		per_q == PERIOD_FAST || per_q == PERIOD_SLOW)
		else $error("pixel period left its two legal values");

	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == PERIOD_NONE || pend_q != per_q)
		else $error("deferred speed equals the speed in force");

	assert property (@(posedge clk) disable iff (!arst_n)
		!motor_q |-> !stylus_q)
		else $error("stylus lowered with the motor stopped");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q) == ST_RES)
		else $error("result raised outside the result state");

	assert property (@(posedge clk) disable iff (!arst_n)
		pix_q >= -10'sd1 && pix_q < 10'sd320)
		else $error("last pixel outside the line");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for stylus_printer_timing_model_core: a clocked driver and monitor,
// with an in-line predictor of the printer head timing that checks every status beat.
// Depends on spt_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;

	import spt_pkg::*;

	typedef struct {
		logic        kind;
		logic [7:0]  ctrl;
		logic [63:0] stamp;
		bit          wait_drain;
	} port_beat_t;

	localparam int unsigned FAST_P = PERIOD_FAST;
	localparam int unsigned SLOW_P = PERIOD_SLOW;
	localparam int unsigned NONE_P = PERIOD_NONE;
	localparam longint PITCH_PX = LINE_SPAN;
	localparam longint LEAD_PX = LEAD_IN;
	localparam longint CROSS_PX = 320;
	localparam longint BUSY_EDGE_PX = -10;
	localparam int READY_BIT = 0;
	localparam int RANDOM_BEATS = 1000;
	localparam int LONG_HOLD = 600;
	localparam int SETTLE_CYCLES = 100;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PRINT_CAP = 100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic        kind = KIND_READ;
	logic [7:0]  control_byte = 8'h00;
	logic [63:0] timestamp = 64'd0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [7:0]  status_byte;

	stylus_printer_timing_model_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.kind         (kind),
		.control_byte (control_byte),
		.timestamp    (timestamp),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status_byte  (status_byte)
	);

	port_beat_t  pending_beats[$];
	logic [7:0]  status_expected[$];
	int          beats_taken = 0;
	int          total_beats = 0;
	int          mismatch_count = 0;
	int          quiet_cycles = 0;
	int          hold_left = 0;
	bit          long_hold_done = 0;
	logic [63:0] clock_now = 64'd0;

	// Printer state as the head timing predicts it.
	bit          motor_on;
	bit          pen_down;
	int unsigned cur_period;
	int unsigned next_period;
	logic [63:0] line_origin;
	longint      last_mark;

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		if (mismatch_count < PRINT_CAP)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic longint head_position(logic [63:0] now, logic [63:0] origin,
			int unsigned per);
		logic [63:0] span;
		span = now - origin;
		if (span > 64'(MAX_ELAPSED))
			span = 64'(MAX_ELAPSED);
		return longint'(span / 64'(per)) - LEAD_PX;
	endfunction

	function automatic longint rescale_head(longint x, int unsigned old_p, int unsigned new_p);
		return ((x + LEAD_PX) * longint'(old_p)) / longint'(new_p) - LEAD_PX;
	endfunction

	function automatic logic [7:0] predict_status(logic [63:0] now);
		int unsigned per;
		int unsigned pend;
		longint      x;
		longint      mark;
		logic [7:0]  st;
		if (!motor_on)
			return STATUS_IDLE;
		per = cur_period;
		pend = next_period;
		x = head_position(now, line_origin, per);
		mark = last_mark;
		while (x > CROSS_PX) begin
			mark = -1;
			x = x - PITCH_PX;
			if (pend != NONE_P) begin
				x = rescale_head(x, per, pend);
				per = pend;
				pend = NONE_P;
			end
		end
		st = ((x > BUSY_EDGE_PX && x < 0) || pen_down) ? STATUS_BUSY : STATUS_IDLE;
		if (x > mark)
			st[READY_BIT] = 1'b1;
		return st;
	endfunction

	function automatic void apply_control(logic [7:0] ctrl, logic [63:0] now);
		bit          stop;
		int unsigned want_p;
		int unsigned per;
		longint      x;
		stop = ctrl[CTRL_STOP];
		want_p = ctrl[CTRL_SLOW] ? SLOW_P : FAST_P;
		if (!motor_on) begin
			if (stop)
				return;
			motor_on = 1'b1;
			cur_period = want_p;
			next_period = NONE_P;
			line_origin = now;
			pen_down = ctrl[CTRL_STYLUS];
			last_mark = -1;
			return;
		end
		per = cur_period;
		x = head_position(now, line_origin, per);
		while (x >= CROSS_PX) begin
			line_origin = line_origin + 64'(per) * 64'(PITCH_PX);
			x = x - PITCH_PX;
			if (next_period != NONE_P) begin
				x = rescale_head(x, per, next_period);
				per = next_period;
				cur_period = per;
				next_period = NONE_P;
			end
		end
		if (x < 0)
			x = -1;
		if (stop) begin
			motor_on = 1'b0;
			pen_down = 1'b0;
			return;
		end
		last_mark = x;
		pen_down = ctrl[CTRL_STYLUS];
		if (x < 0) begin
			cur_period = want_p;
			next_period = NONE_P;
		end else begin
			next_period = (want_p == cur_period) ? NONE_P : want_p;
		end
	endfunction

	function automatic int idle_phase();
		if (beats_taken < total_beats / 3)
			return 0;
		if (beats_taken < 2 * total_beats / 3)
			return 1;
		return 2;
	endfunction

	function automatic int sender_idle_pct();
		case (idle_phase())
			0: return 13;
			1: return 72;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct();
		case (idle_phase())
			0: return 72;
			1: return 13;
			default: return 0;
		endcase
	endfunction

	function automatic logic [63:0] next_stamp();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			clock_now += $urandom_range(0, 16000);
		else if (pick < 70)
			clock_now += $urandom_range(0, 90000);
		else if (pick < 85)
			clock_now += $urandom_range(0, 400000);
		else if (pick < 93)
			clock_now += 64'(MAX_ELAPSED) + $urandom_range(0, 30000000);
		else if (pick < 97)
			return clock_now - $urandom_range(1, 200000);
		else
			clock_now = {$urandom, $urandom};
		return clock_now;
	endfunction

	task automatic queue_beat(logic k, logic [7:0] c, logic [63:0] s, bit drain = 0);
		port_beat_t beat;
		beat.kind = k;
		beat.ctrl = c;
		beat.stamp = s;
		beat.wait_drain = drain;
		pending_beats.push_back(beat);
	endtask

	// Driver: presents queued beats and feeds every accepted beat to the predictor.
	always @(posedge clk or negedge arst_n) begin
		port_beat_t beat;
		if (!arst_n) begin
			req_valid <= 1'b0;
			kind <= KIND_READ;
			control_byte <= 8'h00;
			timestamp <= 64'd0;
		end else begin
			if (req_valid && !req_stall) begin
				beats_taken <= beats_taken + 1;
				if (kind == KIND_READ)
					status_expected.push_back(predict_status(timestamp));
				else
					apply_control(control_byte, timestamp);
			end
			if (!req_valid || !req_stall) begin
				if (pending_beats.size() != 0
						&& !(pending_beats[0].wait_drain && status_expected.size() != 0)
						&& $urandom_range(0, 99) >= sender_idle_pct()) begin
					beat = pending_beats.pop_front();
					req_valid <= 1'b1;
					kind <= beat.kind;
					control_byte <= beat.ctrl;
					timestamp <= beat.stamp;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks status beats in order and drives the receiver stall.
	always @(posedge clk or negedge arst_n) begin
		logic [7:0] want;
		bit         stall_next;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (status_expected.size() == 0) begin
					report_mismatch($sformatf("status %02h with no read waiting", status_byte));
				end else begin
					want = status_expected.pop_front();
					if (status_byte !== want)
						report_mismatch($sformatf("status %02h, expected %02h",
							status_byte, want));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (!long_hold_done && beats_taken > total_beats / 6) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				stall_next = 1'b1;
			end else begin
				stall_next = $urandom_range(0, 99) < receiver_idle_pct();
			end
			rsp_stall <= stall_next;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int         session;
		int         n;
		int         directed;
		logic [7:0] c;
		motor_on = 1'b0;
		pen_down = 1'b0;
		cur_period = FAST_P;
		next_period = NONE_P;
		line_origin = 64'd0;
		last_mark = -1;

		queue_beat(KIND_READ, 8'h00, 64'd0);
		queue_beat(KIND_WRITE, 8'h86, 64'd100);
		queue_beat(KIND_READ, 8'hff, 64'd200);
		queue_beat(KIND_WRITE, 8'h80, 64'd1000);
		queue_beat(KIND_READ, 8'h00, 64'd1000);
		queue_beat(KIND_READ, 8'h00, 64'd13980);
		queue_beat(KIND_WRITE, 8'h02, 64'd14200);
		queue_beat(KIND_READ, 8'h00, 64'd14200);
		queue_beat(KIND_READ, 8'h00, 64'd1000 + 64'd440 * 70);
		queue_beat(KIND_WRITE, 8'h00, 64'd1000 + 64'd440 * 100);
		queue_beat(KIND_READ, 8'h00, 64'd1000 + 64'd440 * 100 + 64'd10);
		queue_beat(KIND_READ, 8'h00, 64'd1000 + 64'd440 * 500);
		queue_beat(KIND_WRITE, 8'h80, 64'd1000 + 64'd440 * 800);
		queue_beat(KIND_READ, 8'h00, 64'd1000 + 64'd30000000);
		queue_beat(KIND_READ, 8'h00, 64'd500);
		queue_beat(KIND_WRITE, 8'h84, 64'd40000000);
		queue_beat(KIND_READ, 8'h00, 64'd40000001);
		queue_beat(KIND_WRITE, 8'hff, 64'd40000002);
		queue_beat(KIND_WRITE, 8'h7b, 64'hffff_ffff_ffff_0000);
		queue_beat(KIND_READ, 8'h00, 64'hffff_ffff_ffff_ffff);
		queue_beat(KIND_WRITE, 8'h80, 64'h0000_0000_0010_0000);
		queue_beat(KIND_READ, 8'h00, 64'h0000_0000_0020_0000);
		queue_beat(KIND_WRITE, 8'h04, 64'h0000_0000_0030_0000, 1'b1);
		directed = pending_beats.size();
		clock_now = 64'h0000_0000_0040_0000;

		// Sessions: a motor start, a run of reads and writes at mostly advancing times, a stop.
		// A few beats of noise with random times are mixed in.
		session = 0;
		while (pending_beats.size() < directed + RANDOM_BEATS) begin
			session++;
			c = 8'($urandom_range(0, 255));
			c[CTRL_STOP] = 1'b0;
			queue_beat(KIND_WRITE, c, next_stamp(), session % 8 == 3);
			n = $urandom_range(4, 40);
			repeat (n) begin
				c = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 99) < 8) begin
					queue_beat(1'($urandom_range(0, 1)), c, {$urandom, $urandom});
				end else if ($urandom_range(0, 99) < 55) begin
					queue_beat(KIND_READ, c, next_stamp());
				end else begin
					c[CTRL_STOP] = $urandom_range(0, 99) < 10;
					queue_beat(KIND_WRITE, c, next_stamp());
				end
			end
			c = 8'($urandom_range(0, 255));
			c[CTRL_STOP] = 1'b1;
			queue_beat(KIND_WRITE, c, next_stamp());
		end
		total_beats = pending_beats.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_beats.size() != 0 || req_valid)
			@(posedge clk);
		while (status_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/spt_pkg.sv
hw/rtl/stylus_printer_timing_model_core.sv
tb/tb.sv
